// File: hw/rtl/integer_literal_classifier_assert.svh
// ============================================================================
// Assertion macros for the integer literal classifier
// Shared helpers that wrap concurrent assertions clocked on the block clock.
// ============================================================================
`ifndef INTEGER_LITERAL_CLASSIFIER_ASSERT_SVH
`define INTEGER_LITERAL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define ILC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ILC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ilc_pkg.sv
// ============================================================================
// ilc_pkg
// Types and character constants shared by the integer literal classifier.
// ============================================================================
package ilc_pkg;

    // Token classes as they appear on the result port.
    typedef enum logic [1:0] {
        CLS_OCT = 2'd0,
        CLS_DEC = 2'd1,
        CLS_HEX = 2'd2,
        CLS_UNK = 2'd3
    } t_cls;

    // Work handed from the scanner to the counter stage.
    typedef struct packed {
        logic emit;   // a token closed: produce a result beat
        logic clear;  // end of text: zero the counts after any result
        t_cls cls;
    } t_op;

    localparam int unsigned OUT_COUNT_WIDTH = 16;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_SEVEN = 8'h37;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_X_LO  = 8'h78;
    localparam logic [7:0] CHR_X_UP  = 8'h58;
    localparam logic [7:0] CHR_A_UP  = 8'h41;
    localparam logic [7:0] CHR_F_UP  = 8'h46;
    localparam logic [7:0] CHR_A_LO  = 8'h61;
    localparam logic [7:0] CHR_F_LO  = 8'h66;
    localparam logic [7:0] SEP_RESET = 8'h26;

endpackage

// File: hw/rtl/ilc_front.sv
// ============================================================================
// ilc_front
// Byte scanner: splits tokens at the separator and runs the literal automaton.
// ============================================================================
module ilc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_wdata,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char_code,
    input  logic           i_end_of_text,
    input  logic           i_q_full,
    output logic           o_push,
    output ilc_pkg::t_op   o_push_op
);
    import ilc_pkg::*;

    typedef enum logic [2:0] {
        ST_START = 3'd0,
        ST_OCT1  = 3'd1,
        ST_OCT2  = 3'd2,
        ST_HEX1  = 3'd3,
        ST_HEX2  = 3'd4,
        ST_DEC   = 3'd5,
        ST_MINUS = 3'd6,
        ST_UNK   = 3'd7
    } t_scan;

    t_scan      r_state, n_state;
    logic       r_open, n_open;
    logic [7:0] r_sep;
    logic       accept, is_eot, is_sep;
    t_scan      step_state;
    t_cls       cur_cls;

    function automatic logic f_dec(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

    function automatic logic f_oct(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_SEVEN);
    endfunction

    function automatic logic f_hex(input logic [7:0] c);
        return f_dec(c) || ((c >= CHR_A_UP) && (c <= CHR_F_UP))
            || ((c >= CHR_A_LO) && (c <= CHR_F_LO));
    endfunction

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_eot  = i_end_of_text || (i_char_code == CHR_NUL);
    assign is_sep  = (i_char_code == r_sep);

    always_comb begin
        unique case (r_state)
            ST_START: begin
                if (i_char_code == CHR_ZERO)       step_state = ST_OCT1;
                else if (f_dec(i_char_code))       step_state = ST_DEC;
                else if (i_char_code == CHR_MINUS) step_state = ST_MINUS;
                else                               step_state = ST_UNK;
            end
            ST_OCT1: begin
                if (i_char_code == CHR_X_LO || i_char_code == CHR_X_UP) step_state = ST_HEX1;
                else if (f_oct(i_char_code))                            step_state = ST_OCT2;
                else                                                    step_state = ST_UNK;
            end
            ST_OCT2:          step_state = f_oct(i_char_code) ? ST_OCT2 : ST_UNK;
            ST_HEX1, ST_HEX2: step_state = f_hex(i_char_code) ? ST_HEX2 : ST_UNK;
            ST_DEC, ST_MINUS: step_state = f_dec(i_char_code) ? ST_DEC : ST_UNK;
            ST_UNK:           step_state = ST_UNK;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_OCT1, ST_OCT2: cur_cls = CLS_OCT;
            ST_HEX2:          cur_cls = CLS_HEX;
            ST_DEC:           cur_cls = CLS_DEC;
            ST_START, ST_HEX1, ST_MINUS, ST_UNK: cur_cls = CLS_UNK;
        endcase
    end

    always_comb begin
        n_state         = r_state;
        n_open          = r_open;
        o_push          = 1'b0;
        o_push_op.emit  = r_open;
        o_push_op.clear = 1'b0;
        o_push_op.cls   = cur_cls;
        if (accept) begin
            priority if (is_eot) begin
                // End of text always travels down, so the counts clear in order.
                o_push          = 1'b1;
                o_push_op.clear = 1'b1;
                n_state         = ST_START;
                n_open          = 1'b0;
            end else if (is_sep) begin
                o_push  = r_open;
                n_state = ST_START;
                n_open  = 1'b0;
            end else begin
                n_state = step_state;
                n_open  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_open  <= 1'b0;
            r_sep   <= SEP_RESET;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            if (i_cfg_we) begin
                r_sep <= i_cfg_wdata;
            end
        end
    end

endmodule

// File: hw/rtl/ilc_queue.sv
// ============================================================================
// ilc_queue
// Two-entry register queue between the scanner and the counter stage.
// ============================================================================
module ilc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ilc_pkg::t_op   i_push_op,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output ilc_pkg::t_op   o_head_op
);
    import ilc_pkg::*;

    t_op        r_entry [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full       = (r_fill == 2'd2);
    assign o_head_valid = (r_fill != 2'd0);
    assign o_head_op    = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:        r_fill <= r_fill + 2'd1;
                2'b01:        r_fill <= r_fill - 2'd1;
                2'b00, 2'b11: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// File: hw/rtl/ilc_back.sv
// ============================================================================
// ilc_back
// Counter stage: keeps the saturating class counts and the result register.
// ============================================================================
module ilc_back #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_head_valid,
    input  ilc_pkg::t_op                         i_head_op,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output ilc_pkg::t_cls                        o_token_class,
    output logic [ilc_pkg::OUT_COUNT_WIDTH-1:0]  o_class_count
);
    import ilc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_oct, r_dec, r_hex;
    logic [COUNT_WIDTH-1:0] cur_count, new_count;
    logic [COUNT_WIDTH+OUT_COUNT_WIDTH-1:0] wide_count;
    logic                   r_valid;
    t_cls                   r_cls;
    logic [OUT_COUNT_WIDTH-1:0] r_count;

    // A result beat needs a free output register; a bare clear does not.
    assign o_pop = i_head_valid && (!i_head_op.emit || !r_valid || i_ready);

    always_comb begin
        unique case (i_head_op.cls)
            CLS_OCT: cur_count = r_oct;
            CLS_DEC: cur_count = r_dec;
            CLS_HEX: cur_count = r_hex;
            CLS_UNK: cur_count = '0;
        endcase
    end

    always_comb begin
        if (i_head_op.cls == CLS_UNK)      new_count = '0;
        else if (cur_count == COUNT_MAX)   new_count = cur_count;
        else                               new_count = cur_count + 1'b1;
    end

    assign wide_count = {{OUT_COUNT_WIDTH{1'b0}}, new_count};

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head_op.emit) begin
            r_cls   <= i_head_op.cls;
            r_count <= wide_count[OUT_COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_oct   <= '0;
            r_dec   <= '0;
            r_hex   <= '0;
        end else begin
            if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_head_op.emit) begin
                    r_valid <= 1'b1;
                    unique case (i_head_op.cls)
                        CLS_OCT: r_oct <= new_count;
                        CLS_DEC: r_dec <= new_count;
                        CLS_HEX: r_hex <= new_count;
                        CLS_UNK: ;
                    endcase
                end
                if (i_head_op.clear) begin
                    r_oct <= '0;
                    r_dec <= '0;
                    r_hex <= '0;
                end
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_token_class = r_cls;
    assign o_class_count = r_count;

endmodule

// File: hw/rtl/integer_literal_classifier.sv
// ============================================================================
// integer_literal_classifier
// Splits a byte stream into tokens and classifies each as a C integer literal.
// ============================================================================
// Usage
//   Input channel (i_valid / o_ready): one text byte per beat on i_char_code,
//   with i_end_of_text marking end of text. A zero byte also ends the text.
//   Output channel (o_valid / i_ready): one beat per closed non-empty token,
//   giving its class (octal, decimal, hexadecimal, unrecognised) and the
//   saturating running count of that class, zero for unrecognised tokens.
//   Configuration: i_cfg_we writes i_cfg_wdata into the separator register at
//   once; write it only while the block is idle.
//   Result path: the beat that closes a token is written into the queue, and
//   the counter stage then loads the result register, which raises o_valid.
//   Throughput: one byte per cycle while the queue is not full; the byte
//   scanner's state update is the only per-byte loop.
//   Reset (synchronous, active low) returns the scanner to its start state,
//   empties the queue, zeroes the counts and restores the separator to '&'.
//   When the receiver stalls, the result stays in the output register and a
//   two-entry queue absorbs further closed tokens; the input is held off only
//   once that queue is full.
// ============================================================================
module integer_literal_classifier #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_token_class,
    output logic [15:0] o_class_count
);
    import ilc_pkg::*;

    // Work items from the scanner; each closed token or end of text is one.
    logic push, q_full, pop, head_valid;
    t_op  push_op, head_op;
    t_cls token_class;

    // The scanner tracks the automaton state and the separator register.
    ilc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_code  (i_char_code),
        .i_end_of_text(i_end_of_text),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_op    (push_op)
    );

    // The queue decouples the scanner from a stalled output.
    ilc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_op   (push_op),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_head_valid(head_valid),
        .o_head_op   (head_op)
    );

    // The counter stage bumps counts, clears them at end of text and drives
    // the result register.
    ilc_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_op    (head_op),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_token_class(token_class),
        .o_class_count(o_class_count)
    );

    assign o_token_class = token_class;

endmodule

// File: hw/rtl/ilc_checker.sv
// ============================================================================
// ilc_checker
// Port-level checks for the integer literal classifier, bound to the top.
// ============================================================================
`include "integer_literal_classifier_assert.svh"

module ilc_checker #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_char_code,
    input logic        i_end_of_text,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_token_class,
    input logic [15:0] o_class_count
);
    import ilc_pkg::*;

    logic        in_stall, out_stall, unk_beat, known_beat;
    logic [9:0]  in_word;
    logic [18:0] out_word;

    assign in_stall   = i_valid && !o_ready;
    assign out_stall  = o_valid && !i_ready;
    assign in_word    = {i_valid, i_char_code, i_end_of_text};
    assign out_word   = {o_valid, o_token_class, o_class_count};
    assign unk_beat   = o_valid && (o_token_class == CLS_UNK);
    // A recognised token counts itself, so its count is never zero unless
    // the low bits of a wide counter have wrapped.
    assign known_beat = o_valid && (o_token_class != CLS_UNK) && (COUNT_WIDTH <= 16);

    // A byte beat waiting on the block keeps its contents.
    `ILC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_stall, $stable(in_word), "input beat moved")

    // A result beat waiting on the receiver keeps its contents.
    `ILC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable(out_word), "result moved")

    // An unrecognised token always reports a zero count.
    `ILC_ASSERT_NOW(a_unk_zero, i_clk, i_rst_n, unk_beat, o_class_count == 16'd0, "unk count")

    `ILC_ASSERT_NOW(a_known_nonzero, i_clk, i_rst_n, known_beat, o_class_count != 16'd0, "zero count")

endmodule

bind integer_literal_classifier ilc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_ilc_checker (.*);
